### design/assert_macros.svh
// Assertion macros used by the Kalman gain divider (kmu_div).
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Plain clocked property, held off during reset.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`else

`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

### design/kmu_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants, register codes and pipeline payload types
// for the scalar Kalman mean update unit. No dependencies.
package kmu_pkg;

   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int ADDR_W   = 3;
   localparam int ERRVAR_W = 33;   // unsigned Q17.16
   localparam int DELTA_W  = 33;   // signed Q17.16
   localparam int MAG_W    = 33;
   localparam int NOISE_W  = 49;
   localparam int DENOM_W  = 50;
   localparam int GAIN_W   = 17;   // Q1.16, 0..1.0 inclusive
   localparam int PROD_W   = 50;
   localparam int ADJ_W    = 35;
   localparam int DIV_STAGES = 8;

   localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h1_0000;

   localparam logic [DATA_W-1:0] NOISE_VAR_RESET = 32'h0000_0000;
   localparam logic [DATA_W-1:0] VEL_SCALE_RESET = 32'h0001_0000;

   localparam logic signed [ADJ_W-1:0] MEAN_MAX = 35'sh0_7FFF_FFFF;
   localparam logic signed [ADJ_W-1:0] MEAN_MIN = 35'sh7_8000_0000;

   typedef enum logic [0:0] {
      REG_NOISE_VARIANCE = 1'b0,
      REG_VEL_SCALE      = 1'b1
   } kmu_reg_type;

   typedef struct packed {
      logic [DATA_W-1:0] noise_variance;
      logic [DATA_W-1:0] vel_scale;
   } kmu_cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] velocity;
      logic signed [DATA_W-1:0] mean_in;
      logic [DATA_W-1:0]        variance_in;
   } kmu_in_type;

   // Front end to divider.
   typedef struct packed {
      logic signed [DATA_W-1:0] mean;
      logic                     neg;
      logic [MAG_W-1:0]         mag;
      logic [ERRVAR_W-1:0]      errvar;
      logic [DENOM_W-1:0]       denom;
   } kmu_item_type;

   // Divider to back end.
   typedef struct packed {
      logic signed [DATA_W-1:0] mean;
      logic                     neg;
      logic [MAG_W-1:0]         mag;
      logic [ERRVAR_W-1:0]      errvar;
      logic [GAIN_W-1:0]        gain;
   } kmu_gain_type;

endpackage

### design/kmu_req_if.sv
`timescale 1ns / 1ps
// Request channel: velocity sample, mean and variance before update.
// Depends on kmu_pkg.
interface kmu_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [kmu_pkg::DATA_W-1:0] velocity;
   logic signed [kmu_pkg::DATA_W-1:0] mean_in;
   logic [kmu_pkg::DATA_W-1:0]        variance_in;

   modport source (output valid, velocity, mean_in, variance_in, input ready);
   modport sink   (input valid, velocity, mean_in, variance_in, output ready);
endinterface

### design/kmu_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: updated mean and corrected variance.
// Depends on kmu_pkg.
interface kmu_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [kmu_pkg::DATA_W-1:0] mean_out;
   logic [kmu_pkg::DATA_W-1:0]        variance_out;

   modport source (output valid, mean_out, variance_out, input ready);
   modport sink   (input valid, mean_out, variance_out, output ready);
endinterface

### design/scalar_kalman_mean_update_unit.sv
`timescale 1ns / 1ps
// Scalar Kalman mean update unit: top level, register file and the
// front, divider and back pipeline sections. Depends on kmu_pkg and both
// channel interfaces.
//
//   Channel  Direction  Carries
//   req      in         velocity, mean_in, variance_in
//   rsp      out        mean_out, variance_out
//   csr      in/out     noise_variance (0x0), vel_scale (0x4)
//
// One request enters per cycle while the pipeline advances. It passes 4 front
// stages (add, magnitude, noise multiply, denominator), 8 divider stages at two
// gain bits each (three in the first) and 3 back stages ending in the response register.
// Synchronous active-high reset clears all valid bits and loads the register reset values.
// A stalled response freezes every stage, bubbles included; while the
// response register is empty the pipeline advances whatever rsp ready does.
module scalar_kalman_mean_update_unit (
   input  logic                       clock,
   input  logic                       reset,
   kmu_req_if.sink                    req,
   kmu_rsp_if.source                  rsp,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [kmu_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [kmu_pkg::DATA_W-1:0] csr_pwdata,
   output logic [kmu_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   kmu_pkg::kmu_cfg_type  cfg;
   kmu_pkg::kmu_in_type   in_item;
   kmu_pkg::kmu_item_type front_item;
   kmu_pkg::kmu_gain_type div_item;
   logic                  front_valid;
   logic                  div_valid;
   logic                  rsp_valid;
   logic                  advance;

   // advance while the response register is empty or being drained
   assign advance   = !rsp_valid || rsp.ready;
   assign req.ready = advance;

   assign in_item.velocity    = req.velocity;
   assign in_item.mean_in     = req.mean_in;
   assign in_item.variance_in = req.variance_in;

   kmu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kmu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req.valid),
      .in_item   (in_item),
      .cfg       (cfg),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   kmu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   kmu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (div_valid),
      .in_item      (div_item),
      .out_valid    (rsp_valid),
      .mean_out     (rsp.mean_out),
      .variance_out (rsp.variance_out)
   );

   assign rsp.valid = rsp_valid;

endmodule

### design/kmu_csr.sv
`timescale 1ns / 1ps
// APB-style register file: process noise variance and velocity scale.
// Depends on kmu_pkg.
module kmu_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [kmu_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [kmu_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [kmu_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   output kmu_pkg::kmu_cfg_type         cfg
);

   logic [kmu_pkg::DATA_W-1:0] noise_variance_ff;
   logic [kmu_pkg::DATA_W-1:0] vel_scale_ff;
   kmu_pkg::kmu_reg_type       reg_sel;
   logic                       wr_en;

   // word address: byte offset bits are ignored
   assign reg_sel    = kmu_pkg::kmu_reg_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_variance_ff <= kmu_pkg::NOISE_VAR_RESET;
         vel_scale_ff      <= kmu_pkg::VEL_SCALE_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            kmu_pkg::REG_NOISE_VARIANCE: noise_variance_ff <= csr_pwdata;
            kmu_pkg::REG_VEL_SCALE:      vel_scale_ff      <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         kmu_pkg::REG_NOISE_VARIANCE: csr_prdata = noise_variance_ff;
         kmu_pkg::REG_VEL_SCALE:      csr_prdata = vel_scale_ff;
         default:                     csr_prdata = '0;
      endcase
   end

   assign cfg.noise_variance = noise_variance_ff;
   assign cfg.vel_scale      = vel_scale_ff;

endmodule

### design/kmu_front.sv
`timescale 1ns / 1ps
// Front end: predicted error variance, fluctuation magnitude, measurement
// noise and gain denominator over four stages. Depends on kmu_pkg.
module kmu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  kmu_pkg::kmu_in_type  in_item,
   input  kmu_pkg::kmu_cfg_type cfg,
   output logic                 out_valid,
   output kmu_pkg::kmu_item_type out_item
);

   typedef struct packed {
      logic signed [kmu_pkg::DATA_W-1:0]  mean;
      logic [kmu_pkg::ERRVAR_W-1:0]       errvar;
      logic signed [kmu_pkg::DELTA_W-1:0] delta;
   } s1_type;

   typedef struct packed {
      logic signed [kmu_pkg::DATA_W-1:0] mean;
      logic [kmu_pkg::ERRVAR_W-1:0]      errvar;
      logic                              neg;
      logic [kmu_pkg::MAG_W-1:0]         mag;
   } s2_type;

   typedef struct packed {
      logic signed [kmu_pkg::DATA_W-1:0] mean;
      logic [kmu_pkg::ERRVAR_W-1:0]      errvar;
      logic                              neg;
      logic [kmu_pkg::MAG_W-1:0]         mag;
      logic [kmu_pkg::NOISE_W-1:0]       noise;
   } s3_type;

   localparam int MUL_W = kmu_pkg::MAG_W + kmu_pkg::DATA_W;

   s1_type                s1_in, s1_ff;
   s2_type                s2_in, s2_ff;
   s3_type                s3_in, s3_ff;
   kmu_pkg::kmu_item_type s4_in, s4_ff;
   logic [3:0]            vld_in, vld_ff;
   logic [MUL_W-1:0]      noise_prod;

   always_comb begin
      s1_in.mean   = in_item.mean_in;
      s1_in.errvar = {1'b0, in_item.variance_in} + {1'b0, cfg.noise_variance};
      s1_in.delta  = {in_item.velocity[kmu_pkg::DATA_W-1], in_item.velocity}
                   - {in_item.mean_in[kmu_pkg::DATA_W-1], in_item.mean_in};
   end

   always_comb begin
      s2_in.mean   = s1_ff.mean;
      s2_in.errvar = s1_ff.errvar;
      s2_in.neg    = s1_ff.delta[kmu_pkg::DELTA_W-1];
      s2_in.mag    = s2_in.neg ? (~s1_ff.delta + 1'b1) : s1_ff.delta;
   end

   assign noise_prod = MUL_W'(s2_ff.mag) * MUL_W'(cfg.vel_scale);

   always_comb begin
      s3_in.mean   = s2_ff.mean;
      s3_in.errvar = s2_ff.errvar;
      s3_in.neg    = s2_ff.neg;
      s3_in.mag    = s2_ff.mag;
      // truncate to Q.16
      s3_in.noise  = noise_prod[MUL_W-1:kmu_pkg::FRAC_W];
   end

   always_comb begin
      s4_in.mean   = s3_ff.mean;
      s4_in.neg    = s3_ff.neg;
      s4_in.mag    = s3_ff.mag;
      s4_in.errvar = s3_ff.errvar;
      s4_in.denom  = kmu_pkg::DENOM_W'(s3_ff.errvar) + kmu_pkg::DENOM_W'(s3_ff.noise);
   end

   assign vld_in = {vld_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_item  = s4_ff;

endmodule

### design/kmu_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for the Kalman gain errvar/denom in Q1.16,
// two quotient bits per stage (three in the first). Depends on kmu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module kmu_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  kmu_pkg::kmu_item_type in_item,
   output logic                  out_valid,
   output kmu_pkg::kmu_gain_type out_item
);

   localparam int DW = kmu_pkg::DENOM_W;
   localparam int GW = kmu_pkg::GAIN_W;
   localparam int NS = kmu_pkg::DIV_STAGES;

   typedef struct packed {
      logic signed [kmu_pkg::DATA_W-1:0] mean;
      logic                              neg;
      logic [kmu_pkg::MAG_W-1:0]         mag;
      logic [kmu_pkg::ERRVAR_W-1:0]      errvar;
      logic [DW-1:0]                     denom;
      logic [DW-1:0]                     rem;
      logic [GW-1:0]                     quo;
   } div_stage_type;

   // One restoring step: returns {quotient bit, new remainder}.
   function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                            input logic [DW-1:0] den);
      logic [DW:0] twice;
      logic [DW:0] diff;
      twice = {rem, 1'b0};
      diff  = twice - {1'b0, den};
      if (twice >= {1'b0, den}) begin
         return {1'b1, diff[DW-1:0]};
      end else begin
         return {1'b0, twice[DW-1:0]};
      end
   endfunction

   div_stage_type   st_in [NS];
   div_stage_type   st_ff [NS];
   logic [NS-1:0]   vld_in, vld_ff;
   div_stage_type   last;

   // First stage: integer bit (errvar <= denom, so it is 1 only on equality)
   // and the two leading fraction bits.
   always_comb begin
      logic [DW-1:0] rem0;
      logic          qint;
      logic [DW:0]   a;
      logic [DW:0]   b;
      rem0 = DW'(in_item.errvar);
      qint = (rem0 >= in_item.denom);
      if (qint) begin
         rem0 = rem0 - in_item.denom;
      end
      a = div_step(rem0, in_item.denom);
      b = div_step(a[DW-1:0], in_item.denom);
      st_in[0].mean   = in_item.mean;
      st_in[0].neg    = in_item.neg;
      st_in[0].mag    = in_item.mag;
      st_in[0].errvar = in_item.errvar;
      st_in[0].denom  = in_item.denom;
      st_in[0].rem    = b[DW-1:0];
      st_in[0].quo    = {{(GW-3){1'b0}}, qint, a[DW], b[DW]};
   end

   for (genvar s = 1; s < NS; s++) begin : g_stage
      always_comb begin
         logic [DW:0] a;
         logic [DW:0] b;
         a = div_step(st_ff[s-1].rem, st_ff[s-1].denom);
         b = div_step(a[DW-1:0], st_ff[s-1].denom);
         st_in[s]     = st_ff[s-1];
         st_in[s].rem = b[DW-1:0];
         st_in[s].quo = {st_ff[s-1].quo[GW-3:0], a[DW], b[DW]};
      end
   end

   assign vld_in = {vld_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NS; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign last = st_ff[NS-1];

   // Integer bit set means gain is exactly 1.0; this also covers a zero
   // denominator, where every step sets its bit.
   always_comb begin
      out_item.mean   = last.mean;
      out_item.neg    = last.neg;
      out_item.mag    = last.mag;
      out_item.errvar = last.errvar;
      out_item.gain   = last.quo[GW-1] ? kmu_pkg::ONE_Q16 : {1'b0, last.quo[GW-2:0]};
   end

   assign out_valid = vld_ff[NS-1];

   `ASSERT_IMPLIES(a_gain_range, clock, reset, out_valid, out_item.gain <= kmu_pkg::ONE_Q16)
   `ASSERT_IMPLIES(a_rem_below, clock, reset, out_valid && last.denom != '0, last.rem < last.denom)
   `ASSERT_IMPLIES(a_zero_denom, clock, reset, out_valid && last.denom == '0, out_item.gain == kmu_pkg::ONE_Q16)
   `ASSERT_AT(a_zero_errvar, clock, reset, out_valid && last.denom != '0 && last.errvar == '0 |-> last.quo == '0)

endmodule

### design/kmu_back.sv
`timescale 1ns / 1ps
// Back end: gain products, variance saturation, mean adjustment rounded
// toward minus infinity and mean saturation, ending in the response register.
// Depends on kmu_pkg.
module kmu_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  kmu_pkg::kmu_gain_type            in_item,
   output logic                             out_valid,
   output logic signed [kmu_pkg::DATA_W-1:0] mean_out,
   output logic [kmu_pkg::DATA_W-1:0]        variance_out
);

   localparam int PW = kmu_pkg::PROD_W;
   localparam int FW = kmu_pkg::FRAC_W;
   localparam int AW = kmu_pkg::ADJ_W;
   localparam int DW = kmu_pkg::DATA_W;

   typedef struct packed {
      logic signed [DW-1:0] mean;
      logic                 neg;
      logic [PW-1:0]        var_prod;
      logic [PW-1:0]        mean_prod;
   } b1_type;

   typedef struct packed {
      logic signed [DW-1:0] mean;
      logic signed [AW-1:0] adj;
      logic [DW-1:0]        var_sat;
   } b2_type;

   b1_type               b1_in, b1_ff;
   b2_type               b2_in, b2_ff;
   logic signed [DW-1:0] mean_in, mean_ff;
   logic [DW-1:0]        var_in, var_ff;
   logic [2:0]           vld_in, vld_ff;

   always_comb begin
      logic [kmu_pkg::GAIN_W-1:0] compl;
      compl           = kmu_pkg::ONE_Q16 - in_item.gain;
      b1_in.mean      = in_item.mean;
      b1_in.neg       = in_item.neg;
      b1_in.var_prod  = PW'(compl) * PW'(in_item.errvar);
      b1_in.mean_prod = PW'(in_item.gain) * PW'(in_item.mag);
   end

   always_comb begin
      logic [PW-FW-1:0] var_q;
      logic [PW:0]      ceil_sum;
      logic [AW-1:0]    down;
      logic [AW-1:0]    up;
      var_q    = b1_ff.var_prod[PW-1:FW];
      ceil_sum = {1'b0, b1_ff.mean_prod} + (PW+1)'({FW{1'b1}});
      down     = AW'(b1_ff.mean_prod[PW-1:FW]);
      up       = AW'(ceil_sum[PW:FW]);
      b2_in.mean    = b1_ff.mean;
      b2_in.var_sat = (|var_q[PW-FW-1:DW]) ? {DW{1'b1}} : var_q[DW-1:0];
      // negative fluctuation: round the magnitude up, then negate
      b2_in.adj     = b1_ff.neg ? -$signed(up) : $signed(down);
   end

   always_comb begin
      logic signed [AW-1:0] sum;
      sum = $signed(AW'(b2_ff.mean)) + b2_ff.adj;
      if (sum > kmu_pkg::MEAN_MAX) begin
         mean_in = kmu_pkg::MEAN_MAX[DW-1:0];
      end else if (sum < kmu_pkg::MEAN_MIN) begin
         mean_in = kmu_pkg::MEAN_MIN[DW-1:0];
      end else begin
         mean_in = sum[DW-1:0];
      end
      var_in = b2_ff.var_sat;
   end

   assign vld_in = {vld_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_ff   <= b1_in;
         b2_ff   <= b2_in;
         mean_ff <= mean_in;
         var_ff  <= var_in;
      end
   end

   assign out_valid    = vld_ff[2];
   assign mean_out     = mean_ff;
   assign variance_out = var_ff;

endmodule

### tb/scalar_kalman_mean_update_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the scalar Kalman mean update unit: directed table,
// then randomised requests under several register settings, with backpressure.
// Depends on kmu_pkg, kmu_req_if, kmu_rsp_if and the unit itself.
module scalar_kalman_mean_update_unit_tb;

   localparam int CLOCK_HALF      = 10;
   localparam int RESET_CYCLES    = 8;
   localparam int PIPE_DRAIN      = 30;
   localparam int LONG_HOLD       = 120;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_REQUESTS  = 106;
   localparam int DIRECTED_ROWS   = 16;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic signed [kmu_pkg::DATA_W-1:0] mean_out;
      logic [kmu_pkg::DATA_W-1:0]        variance_out;
   } kalman_result_type;

   typedef struct packed {
      logic [kmu_pkg::DATA_W-1:0] noise_var;
      logic [kmu_pkg::DATA_W-1:0] vel_scale;
      kmu_pkg::kmu_in_type        sample;
      logic                       known;
      logic [kmu_pkg::DATA_W-1:0] known_mean;
      logic [kmu_pkg::DATA_W-1:0] known_var;
   } directed_row_type;

   logic clock;
   logic reset;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [kmu_pkg::ADDR_W-1:0] csr_paddr;
   logic [kmu_pkg::DATA_W-1:0] csr_pwdata;
   logic [kmu_pkg::DATA_W-1:0] csr_prdata;
   logic                       csr_pready;

   kmu_req_if req_ch ();
   kmu_rsp_if rsp_ch ();

   scalar_kalman_mean_update_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Tracked register contents.
   logic [kmu_pkg::DATA_W-1:0] cur_noise_var;
   logic [kmu_pkg::DATA_W-1:0] cur_vel_scale;

   kalman_result_type pending_updates [$];

   int     error_count;
   int     results_checked;
   int     requests_sent;
   int     settings_used;
   int     long_holds;
   longint cycle_count;
   bit     gaps_on;
   bit     stalls_on;
   bit     hold_request;

   // Columns: noise_variance, vel_scale, {velocity, mean_in, variance_in},
   // typed-in flag, mean_out, variance_out.
   directed_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{32'h0, 32'h1_0000, '{32'h0, 32'h0, 32'h0}, 1'b1, 32'h0, 32'h0},
      '{32'h0, 32'h1_0000, '{32'h1_0000, 32'h0, 32'h0}, 1'b1, 32'h0, 32'h0},
      '{32'h0, 32'h1_0000, '{32'h0, 32'h0, 32'h1_0000}, 1'b1, 32'h0, 32'h0},
      '{32'h0, 32'h1_0000, '{32'h1_0000, 32'h0, 32'h1_0000}, 1'b1, 32'h8000, 32'h8000},
      '{32'h0, 32'h1_0000, '{32'h2_0000, 32'h0, 32'h1_0000}, 1'b0, 32'h0, 32'h0},
      '{32'h0, 32'h1_0000, '{32'hFFFF_FFFF, 32'h0, 32'h1_0000}, 1'b1, 32'hFFFF_FFFF, 32'h1},
      '{32'h0, 32'h1_0000, '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
        1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF},
      '{32'h0, 32'h1_0000, '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
        1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF},
      '{32'h0, 32'h1_0000, '{32'h8000_0000, 32'h8000_0000, 32'h0},
        1'b1, 32'h8000_0000, 32'h0},
      '{32'h0, 32'h0, '{32'h1234_5678, 32'hFFFF_FFFB, 32'h0}, 1'b1, 32'h1234_5678, 32'h0},
      '{32'h0, 32'h0, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0}, 1'b1, 32'h8000_0000, 32'h0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
        1'b0, 32'h0, 32'h0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, '{32'h0, 32'h0, 32'h0}, 1'b1, 32'h0, 32'h0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
        1'b0, 32'h0, 32'h0},
      '{32'h1_0000, 32'h8000, '{32'h3_0000, 32'hFFFF_0000, 32'h2_0000}, 1'b0, 32'h0, 32'h0},
      '{32'h1_0000, 32'h8000, '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
        1'b0, 32'h0, 32'h0}
   };

   // Gain is Q1.16 capped at one; the mean step rounds toward minus infinity.
   function automatic kalman_result_type kalman_update(
         input kmu_pkg::kmu_in_type s,
         input logic [kmu_pkg::DATA_W-1:0] nv,
         input logic [kmu_pkg::DATA_W-1:0] vs);
      logic [63:0] errvar;
      logic [63:0] mag;
      logic [63:0] noise;
      logic [63:0] denom;
      logic [63:0] gain;
      logic [63:0] var_new;
      logic [63:0] prod;
      longint      delta;
      longint      step;
      longint      sum;
      kalman_result_type r;
      errvar = {32'b0, s.variance_in} + {32'b0, nv};
      delta  = longint'(s.velocity) - longint'(s.mean_in);
      mag    = (delta < 0) ? 64'(-delta) : 64'(delta);
      noise  = (mag * {32'b0, vs}) >> kmu_pkg::FRAC_W;
      denom  = errvar + noise;
      if (denom == 0) begin
         gain = 64'(kmu_pkg::ONE_Q16);
      end else begin
         gain = (errvar << kmu_pkg::FRAC_W) / denom;
      end
      if (gain > 64'(kmu_pkg::ONE_Q16)) begin
         gain = 64'(kmu_pkg::ONE_Q16);
      end
      var_new = ((64'(kmu_pkg::ONE_Q16) - gain) * errvar) >> kmu_pkg::FRAC_W;
      if (var_new > 64'hFFFF_FFFF) begin
         var_new = 64'hFFFF_FFFF;
      end
      prod = gain * mag;
      if (delta < 0) begin
         step = -longint'((prod + 64'h0000_FFFF) >> kmu_pkg::FRAC_W);
      end else begin
         step = longint'(prod >> kmu_pkg::FRAC_W);
      end
      sum = longint'(s.mean_in) + step;
      if (sum > 64'sd2147483647) begin
         sum = 64'sd2147483647;
      end
      if (sum < -64'sd2147483648) begin
         sum = -64'sd2147483648;
      end
      r.mean_out     = sum[31:0];
      r.variance_out = var_new[31:0];
      return r;
   endfunction

   function automatic logic [kmu_pkg::DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         4, 5: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      clock = 1'b0;
   end

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            long_holds++;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      kalman_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_updates.size() == 0) begin
            $error("unexpected response: mean_out %h variance_out %h",
                   rsp_ch.mean_out, rsp_ch.variance_out);
            error_count++;
         end else begin
            want = pending_updates.pop_front();
            results_checked++;
            if (rsp_ch.mean_out !== want.mean_out) begin
               $error("mean_out mismatch: expected %h, got %h",
                      want.mean_out, rsp_ch.mean_out);
               error_count++;
            end
            if (rsp_ch.variance_out !== want.variance_out) begin
               $error("variance_out mismatch: expected %h, got %h",
                      want.variance_out, rsp_ch.variance_out);
               error_count++;
            end
         end
      end
   end

   task automatic idle_req(input int n);
      repeat (n) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   // Leave valid high after acceptance so back-to-back requests need no drop.
   task automatic send_req(input kmu_pkg::kmu_in_type s, input kalman_result_type want);
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.velocity    <= s.velocity;
      req_ch.mean_in     <= s.mean_in;
      req_ch.variance_in <= s.variance_in;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_updates.push_back(want);
      requests_sent++;
   endtask

   task automatic drain();
      idle_req(1);
      while (pending_updates.size() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input kmu_pkg::kmu_reg_type idx, input logic write,
                             input logic [kmu_pkg::DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (write) begin
         if (idx == kmu_pkg::REG_NOISE_VARIANCE) begin
            cur_noise_var = data;
         end else begin
            cur_vel_scale = data;
         end
      end else if (csr_prdata !== ((idx == kmu_pkg::REG_NOISE_VARIANCE) ? cur_noise_var
                                                                         : cur_vel_scale)) begin
         $error("csr_prdata mismatch: expected %h, got %h",
                (idx == kmu_pkg::REG_NOISE_VARIANCE) ? cur_noise_var : cur_vel_scale,
                csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_config(input logic [kmu_pkg::DATA_W-1:0] nv,
                             input logic [kmu_pkg::DATA_W-1:0] vs);
      csr_access(kmu_pkg::REG_NOISE_VARIANCE, 1'b1, nv);
      csr_access(kmu_pkg::REG_VEL_SCALE, 1'b1, vs);
      csr_access(kmu_pkg::REG_NOISE_VARIANCE, 1'b0, '0);
      csr_access(kmu_pkg::REG_VEL_SCALE, 1'b0, '0);
      settings_used++;
   endtask

   initial begin
      kmu_pkg::kmu_in_type        s;
      kalman_result_type          want;
      logic [kmu_pkg::DATA_W-1:0] nv;
      logic [kmu_pkg::DATA_W-1:0] vs;

      error_count     = 0;
      results_checked = 0;
      requests_sent   = 0;
      settings_used   = 1;
      long_holds      = 0;
      cycle_count     = 0;
      gaps_on         = 1'b1;
      stalls_on       = 1'b1;
      hold_request    = 1'b0;
      cur_noise_var   = kmu_pkg::NOISE_VAR_RESET;
      cur_vel_scale   = kmu_pkg::VEL_SCALE_RESET;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.velocity    <= '0;
      req_ch.mean_in     <= '0;
      req_ch.variance_in <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Reset values must read back before anything is written.
      csr_access(kmu_pkg::REG_NOISE_VARIANCE, 1'b0, '0);
      csr_access(kmu_pkg::REG_VEL_SCALE, 1'b0, '0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].noise_var !== cur_noise_var ||
             directed_rows[i].vel_scale !== cur_vel_scale) begin
            drain();
            set_config(directed_rows[i].noise_var, directed_rows[i].vel_scale);
         end
         s = directed_rows[i].sample;
         if (directed_rows[i].known) begin
            want.mean_out     = directed_rows[i].known_mean;
            want.variance_out = directed_rows[i].known_var;
         end else begin
            want = kalman_update(s, cur_noise_var, cur_vel_scale);
         end
         if (gaps_on && $urandom_range(0, 3) == 0) idle_req($urandom_range(1, 6));
         send_req(s, want);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin nv = 32'h0; vs = 32'hFFFF_FFFF; end
            1: begin nv = 32'hFFFF_FFFF; vs = 32'h0; end
            3: begin
               nv = $urandom_range(0, 32'h0004_0000);
               vs = $urandom_range(0, 32'h0004_0000);
            end
            default: begin nv = pick_word(); vs = pick_word(); end
         endcase
         drain();
         set_config(nv, vs);
         // Fill the pipe against a stalled receiver.
         if (phase == 2) hold_request = 1'b1;
         // Run the final stretch flat out on both sides.
         if (phase == RANDOM_PHASES - 1) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            s.mean_in = pick_word();
            if ($urandom_range(0, 1)) begin
               s.velocity = s.mean_in + ($urandom_range(0, 32'h3_FFFF) - 32'h1_FFFF);
            end else begin
               s.velocity = pick_word();
            end
            s.variance_in = pick_word();
            want = kalman_update(s, cur_noise_var, cur_vel_scale);
            if (gaps_on && $urandom_range(0, 4) == 0) idle_req($urandom_range(1, 6));
            send_req(s, want);
         end
      end

      drain();
      repeat (PIPE_DRAIN) @(posedge clock);

      $display("Run covered %0d requests (%0d directed) under %0d register settings,",
               requests_sent, DIRECTED_ROWS, settings_used);
      $display("with %0d responses checked and %0d long receiver hold-offs.",
               results_checked, long_holds);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
